// ----- rtl/itoa_pkg.sv -----
// Package for the integer to ASCII radix converter.
// Holds the word size, character codes and the digit glyph function.
// No dependencies.
`default_nettype none

package itoa_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int RADIX_W = 6;
    localparam int CHAR_W = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NUL = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'h57;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < RADIX_W'(10)) begin
            digit_glyph = CHAR_ZERO + d_ext;
        end else begin
            digit_glyph = CHAR_ALPHA_BASE + d_ext;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/itoa_div.sv -----
// Bit-serial restoring divider for the integer to ASCII radix converter.
// Divides a word by a small radix, one quotient bit per cycle.
// Depends on itoa_pkg.
`default_nettype none

module itoa_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [itoa_pkg::WORD_BITS-1:0] i_dividend,
    input  wire logic [itoa_pkg::RADIX_W-1:0]   i_divisor,
    output itoa_pkg::t_div_stat                 o_stat,
    output logic [itoa_pkg::WORD_BITS-1:0]      o_quotient,
    output logic [itoa_pkg::RADIX_W-1:0]        o_remainder
);
    import itoa_pkg::*;

    logic [WORD_BITS-1:0] r_work;
    logic [RADIX_W-1:0]   r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [RADIX_W:0]     w_trial;
    logic [RADIX_W:0]     w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_work[WORD_BITS-1]};
    assign w_ge = w_trial >= {1'b0, i_divisor};
    assign w_diff = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                r_busy <= (r_cnt != CNT_W'(WORD_BITS - 1));
                r_done <= (r_cnt == CNT_W'(WORD_BITS - 1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_work <= {r_work[WORD_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[RADIX_W-1:0] : w_trial[RADIX_W-1:0];
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quotient = r_work;
    assign o_remainder = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < i_divisor))
        else $error("Remainder is not below the divisor.");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("Divider did not start.");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("Divider reports done while busy.");

endmodule

`default_nettype wire

// ----- rtl/integer_to_ascii_radix.sv -----
// Top level of the integer to ASCII radix converter.
// Converts a signed word to its text in radix 2 to 36, one character per transfer.
// Depends on itoa_pkg and itoa_div.
//
// Each input transfer carries a 32-bit signed value and a radix. The block
// emits the ASCII text most significant digit first, lower-case letters for
// digits above 9, with tlast on the final character. A negative value gets a
// leading minus sign in radix 10 only; in other radices the digits of the
// magnitude are sent. An invalid radix yields one transfer with character 0,
// tlast and tuser set. Digits are produced by one shared bit-serial divider:
// each digit takes a divider start, the divide steps and a store, and each
// output character is then read from the digit memory before it is emitted.
// The input is not ready until the conversion has ended.
`default_nettype none

module integer_to_ascii_radix (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // value[31:0], radix[37:32], zero pad
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // character[6:0], zero pad
    output logic             o_m_axis_tlast,
    output logic [0:0]       o_m_axis_tuser    // bad_radix[0]
);
    import itoa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MINUS = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_BAD   = 3'd6;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [WORD_BITS-1:0] r_mag;
    logic [RADIX_W-1:0]   r_radix;
    logic                 r_minus;
    logic [CNT_W:0]       r_cnt;

    logic [RADIX_W-1:0]   r_digit_mem [WORD_BITS];
    logic [RADIX_W-1:0]   r_rd_data;

    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;
    logic                 r_out_bad;

    logic                 w_accept;
    logic                 w_slot_free;
    logic [WORD_BITS-1:0] w_in_value;
    logic [RADIX_W-1:0]   w_in_radix;
    logic                 w_radix_ok;
    logic                 w_negative;
    logic                 w_div_start;
    logic                 w_store;
    logic                 w_digits_done;
    logic [CNT_W-1:0]     w_rd_addr;
    t_div_stat            w_div_stat;
    logic [WORD_BITS-1:0] w_quotient;
    logic [RADIX_W-1:0]   w_remainder;

    assign w_in_value = i_s_axis_tdata[WORD_BITS-1:0];
    assign w_in_radix = i_s_axis_tdata[WORD_BITS +: RADIX_W];
    assign w_radix_ok = (w_in_radix >= RADIX_MIN) && (w_in_radix <= RADIX_MAX);
    assign w_negative = w_in_value[WORD_BITS-1];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_out_valid || i_m_axis_tready;

    assign w_div_start = (r_state == S_LOAD);
    assign w_store = (r_state == S_DIV) && w_div_stat.done;
    assign w_digits_done = (w_quotient == '0) || (r_cnt == (CNT_W + 1)'(WORD_BITS - 1));
    assign w_rd_addr = r_cnt[CNT_W-1:0] - 1'b1;

    itoa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_mag),
        .i_divisor   (r_radix),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_radix_ok ? S_LOAD : S_BAD;
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    if (!w_digits_done) begin
                        n_state = S_LOAD;
                    end else if (r_minus) begin
                        n_state = S_MINUS;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_MINUS: begin
                if (w_slot_free) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_state = (r_cnt == (CNT_W + 1)'(1)) ? S_IDLE : S_RD;
                end
            end
            S_BAD: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_minus <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
                r_minus <= w_negative && (w_in_radix == RADIX_DEC);
            end
            if (w_store) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_slot_free) begin
                r_out_valid <= (r_state == S_MINUS || r_state == S_EMIT ||
                                r_state == S_BAD);
                if (r_state == S_MINUS) begin
                    r_minus <= 1'b0;
                end
                if (r_state == S_EMIT) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag <= w_negative ? (~w_in_value + 1'b1) : w_in_value;
            r_radix <= w_in_radix;
        end else if (w_store) begin
            r_mag <= w_quotient;
        end
        if (w_slot_free) begin
            unique case (r_state)
                S_MINUS: begin
                    r_out_char <= CHAR_MINUS;
                    r_out_last <= 1'b0;
                    r_out_bad <= 1'b0;
                end
                S_EMIT: begin
                    r_out_char <= digit_glyph(r_rd_data);
                    r_out_last <= (r_cnt == (CNT_W + 1)'(1));
                    r_out_bad <= 1'b0;
                end
                S_BAD: begin
                    r_out_char <= CHAR_NUL;
                    r_out_last <= 1'b1;
                    r_out_bad <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_digit_mem[r_cnt[CNT_W-1:0]] <= w_remainder;
        end
        r_rd_data <= r_digit_mem[w_rd_addr];
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {1'b0, r_out_char};
    assign o_m_axis_tlast = r_out_last;
    assign o_m_axis_tuser = r_out_bad;

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("Bad radix transfer is not marked last.");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (CNT_W + 1)'(WORD_BITS))
        else $error("Digit count exceeds the word size.");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide state.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("Input ready right after a transfer.");

endmodule

`default_nettype wire

// ----- test/itoa_text_check_pkg.sv -----
// Scoreboard for the integer to ASCII radix converter testbench.
// Predicts the character transfers of each conversion and checks them in order.
// Depends on itoa_pkg.
package itoa_text_check_pkg;

    import itoa_pkg::*;

    localparam logic [CHAR_W-1:0] GLYPH_LOWER_A = 7'h61;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_radix;
    } t_text_char;

    class t_text_scoreboard;
        t_text_char expected_text[$];
        int         error_count = 0;

        function void note_conversion(logic [WORD_BITS-1:0] value, logic [RADIX_W-1:0] radix);
            logic [WORD_BITS-1:0] magnitude;
            logic [RADIX_W-1:0]   digit;
            logic [CHAR_W-1:0]    glyph;
            logic [CHAR_W-1:0]    digit_text[$];
            int                   i;
            if (radix < RADIX_MIN || radix > RADIX_MAX) begin
                expected_text.push_back('{character: CHAR_NUL, last: 1'b1, bad_radix: 1'b1});
            end else begin
                magnitude = value[WORD_BITS-1] ? (~value + 1'b1) : value;
                do begin
                    digit = RADIX_W'(magnitude % WORD_BITS'(radix));
                    magnitude = magnitude / WORD_BITS'(radix);
                    if (digit < RADIX_DEC) begin
                        glyph = CHAR_ZERO + CHAR_W'(digit);
                    end else begin
                        glyph = GLYPH_LOWER_A + CHAR_W'(digit - RADIX_DEC);
                    end
                    digit_text.push_front(glyph);
                end while (magnitude != 0);
                if (value[WORD_BITS-1] && radix == RADIX_DEC) begin
                    expected_text.push_back('{character: CHAR_MINUS, last: 1'b0,
                                              bad_radix: 1'b0});
                end
                for (i = 0; i < digit_text.size(); i++) begin
                    expected_text.push_back('{character: digit_text[i],
                                              last: (i == digit_text.size() - 1),
                                              bad_radix: 1'b0});
                end
            end
        endfunction

        function void check_character(logic [CHAR_W-1:0] character, logic last,
                                      logic bad_radix);
            t_text_char want;
            if (expected_text.size() == 0) begin
                $error("unexpected transfer: character %0h last %0b bad_radix %0b",
                       character, last, bad_radix);
                error_count++;
            end else begin
                want = expected_text.pop_front();
                if (character !== want.character) begin
                    $error("character: expected %0h, actual %0h", want.character, character);
                    error_count++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, last);
                    error_count++;
                end
                if (bad_radix !== want.bad_radix) begin
                    $error("bad_radix: expected %0b, actual %0b", want.bad_radix, bad_radix);
                    error_count++;
                end
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

endpackage

// ----- test/integer_to_ascii_radix_tb.sv -----
// Testbench top for the integer to ASCII radix converter.
// Drives directed and random conversions under several idle and stall mixes.
// Depends on itoa_pkg, itoa_text_check_pkg and the integer_to_ascii_radix RTL.
module integer_to_ascii_radix_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;
    import itoa_text_check_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEMS_PER_PHASE = 61;
    localparam logic [WORD_BITS-1:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [WORD_BITS-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
    localparam logic [WORD_BITS-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [0:0]  o_m_axis_tuser;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    t_text_scoreboard text_board = new();

    integer_to_ascii_radix dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("integer_to_ascii_radix regression: fail");
                $finish;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_tready) begin
                text_board.check_character(o_m_axis_tdata[CHAR_W-1:0], o_m_axis_tlast,
                                           o_m_axis_tuser[0]);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_conversion(logic [WORD_BITS-1:0] value, logic [RADIX_W-1:0] radix);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= 40'({$urandom, $urandom});
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, radix, value};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        text_board.note_conversion(value, radix);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_value();
        logic [WORD_BITS-1:0] v;
        int kind;
        kind = $urandom_range(9);
        if (kind < 5) begin
            v = $urandom;
        end else if (kind < 8) begin
            v = $urandom >> $urandom_range(31);
            if ($urandom_range(1)) v = -v;
        end else if (kind == 8) begin
            case ($urandom_range(5))
                0: v = '0;
                1: v = MINUS_ONE;
                2: v = MOST_NEGATIVE;
                3: v = MOST_POSITIVE;
                4: v = 32'd1;
                default: v = MOST_NEGATIVE + 32'd1;
            endcase
        end else begin
            v = $urandom_range(40);
            if ($urandom_range(1)) v = -v;
        end
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            return $urandom_range(1) ? RADIX_W'($urandom_range(1))
                                     : RADIX_W'($urandom_range(37, 63));
        end else if (roll < 30) begin
            return RADIX_DEC;
        end else begin
            return RADIX_W'($urandom_range(2, 36));
        end
    endfunction

    initial begin
        int phase;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_conversion('0, RADIX_DEC);
        send_conversion('0, RADIX_MIN);
        send_conversion('0, RADIX_MAX);
        send_conversion(MINUS_ONE, RADIX_DEC);
        send_conversion(MINUS_ONE, RADIX_MIN);
        send_conversion(MINUS_ONE, 6'd16);
        send_conversion(MOST_NEGATIVE, RADIX_DEC);
        send_conversion(MOST_NEGATIVE, RADIX_MIN);
        send_conversion(MOST_NEGATIVE, RADIX_MAX);
        send_conversion(MOST_POSITIVE, RADIX_DEC);
        send_conversion(MOST_POSITIVE, RADIX_MIN);
        send_conversion(MOST_POSITIVE, RADIX_MAX);
        send_conversion(MOST_POSITIVE, 6'd16);
        send_conversion(32'd1, RADIX_MIN);
        send_conversion(32'd35, RADIX_MAX);
        send_conversion(32'd36, RADIX_MAX);
        send_conversion(-32'sd35, RADIX_MAX);
        send_conversion(32'd12345, RADIX_DEC);
        send_conversion(-32'sd987654, RADIX_DEC);
        send_conversion(-32'sd255, 6'd16);
        send_conversion(32'd511, 6'd8);
        send_conversion($urandom, 6'd0);
        send_conversion($urandom, 6'd1);
        send_conversion($urandom, 6'd37);
        send_conversion($urandom, 6'd63);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_conversion(pick_value(), pick_radix());
            end
        end
        s_tvalid <= 1'b0;

        while (text_board.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (text_board.error_count == 0) begin
            $display("integer_to_ascii_radix regression: pass");
        end else begin
            $display("integer_to_ascii_radix regression: fail");
        end
        $finish;
    end

endmodule
